>>> design/kfb_pkg.sv
// ----------------------------------------------------------------------------
// kfb_pkg: shared constants and types of the scalar Kalman filter bank
// Widths, fixed-point constants, register indexes and the divider interface.
// ----------------------------------------------------------------------------
`default_nettype none

package kfb_pkg;

  // Number of filter channels and fractional bits of the fixed-point format.
  localparam int CHANNELS  = 64;
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int CH_W    = 6;
  localparam int VAL_W   = 32;
  localparam int GAIN_W  = FRAC_BITS + 1;
  localparam int SUM_W   = 38;
  localparam int ACT_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed-point constants: 1.0 and 0.5.
  localparam logic [GAIN_W-1:0] ONE_FIX  = GAIN_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0]  ONE_VAL  = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0]  HALF_VAL = VAL_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACT_W-1:0]  ACT_RESET = ACT_W'(64);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS   = 2'd2;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] num;
    logic [VAL_W:0]   den;
  } kfb_div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quot;
  } kfb_div_rsp_t;

endpackage

`default_nettype wire

>>> design/kfb_div.sv
// ----------------------------------------------------------------------------
// kfb_div: iterative gain divider
// Restoring radix-2 division of num * 2^FRAC_BITS by den, one quotient bit
// per cycle, for dividends not larger than the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module kfb_div
  import kfb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire kfb_div_req_t req,
  output kfb_div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [VAL_W:0]    rem_r;
  logic [VAL_W:0]    den_r;
  logic [GAIN_W-1:0] quot_r;

  logic [VAL_W+1:0]  trial;
  logic [VAL_W+1:0]  diff;
  logic              ge;
  logic [VAL_W:0]    rem_nxt;

  // The first step compares the dividend itself, which gives the integer bit
  // of the gain; every later step shifts a zero into the partial remainder.
  always_comb begin
    if (cnt_r == CNT_W'(FRAC_BITS)) begin
      trial = {1'b0, rem_r};
    end else begin
      trial = {rem_r, 1'b0};
    end
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[VAL_W:0] : trial[VAL_W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num};
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[GAIN_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

>>> design/scalar_kalman_filter_bank_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_bank_top: bank of one-dimensional Kalman filters
// Each input beat carries a channel index and a signed Q16.16 measurement.
// The block runs one scalar Kalman update for that channel and returns one
// result beat with the new estimate, the gain, the new variance, the sum of
// all stored estimates and an error flag. An accepted beat passes through the
// memory read, the bit-serial gain division, one shared multiplier used twice
// and the write-back before the next beat can be accepted. A rejected beat
// (channel at or above active_channels, or a zero denominator) skips the
// division and leaves the stores and the running sum unchanged. The result
// sits in an output register, so the next beat is accepted while it waits.
// After reset every estimate is 0 and every variance is 1.0; the stores are
// usable at once, with no clearing pass. Configuration is taken at any time
// (cfg_ready is always high) but is meant to change only while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_bank_top
  import kfb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [VAL_W-1:0]        cfg_data,

  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CH_W-1:0]         in_channel,
  input  wire logic signed [VAL_W-1:0] in_measurement,

  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [CH_W-1:0]              out_channel_out,
  output logic signed [VAL_W-1:0]      out_estimate,
  output logic [GAIN_W-1:0]            out_gain,
  output logic [VAL_W-1:0]             out_variance,
  output logic signed [SUM_W-1:0]     out_estimate_sum,
  output logic                         out_error
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_ADDQ = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_XUPD = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_PUPD = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam int MUL_A_W = VAL_W + 2;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int XS_W    = VAL_W + 3;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Configuration registers.
  logic [VAL_W-1:0] q_r;
  logic [VAL_W-1:0] r_r;
  logic [ACT_W-1:0] act_r;

  // Working registers of the current item.
  logic [CH_W-1:0]         ch_r;
  logic signed [VAL_W-1:0] z_r;
  logic signed [VAL_W-1:0] x_r;
  logic [VAL_W-1:0]        p1_r;
  logic [GAIN_W-1:0]       k_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0] xn_r;
  logic [VAL_W-1:0]        pn_r;
  logic                    err_r;
  logic signed [SUM_W-1:0] sum_r;

  // Channel stores with one valid bit per entry; an entry that was never
  // written reads as its reset value.
  logic [VAL_W-1:0]    est_mem [CHANNELS];
  logic [VAL_W-1:0]    var_mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [VAL_W-1:0]    est_rd_r;
  logic [VAL_W-1:0]    var_rd_r;
  logic                rd_vld_r;
  logic [CH_IDX_W-1:0] idx;

  // Output register.
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic signed [VAL_W-1:0] out_est_r;
  logic [GAIN_W-1:0]       out_gain_r;
  logic [VAL_W-1:0]        out_var_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_err_r;

  logic              in_fire;
  logic              out_load;
  logic              in_range;
  logic [VAL_W:0]    p_sum;
  logic [VAL_W:0]    den;
  logic [VAL_W-1:0]  p_cur;
  logic signed [VAL_W-1:0] x_cur;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [MUL_A_W-1:0] delta;
  logic signed [XS_W-1:0]    xs;
  logic signed [XS_W-1:0]    dx;

  kfb_div_req_t div_req;
  kfb_div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign idx       = CH_IDX_W'(ch_r);

  // A channel is in range only if it lies below both the configured count
  // and the physical number of channels.
  assign in_range = ({1'b0, ch_r} < act_r) && (32'(ch_r) < 32'(CHANNELS));

  assign p_cur = rd_vld_r ? var_rd_r : ONE_VAL;
  assign x_cur = rd_vld_r ? est_rd_r : '0;
  assign p_sum = {1'b0, p_cur} + {1'b0, q_r};
  assign den   = {1'b0, p1_r} + {1'b0, r_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= HALF_VAL;
      r_r   <= HALF_VAL;
      act_r <= ACT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROCESS_NOISE:     q_r   <= cfg_data;
        CFG_MEASUREMENT_NOISE: r_r   <= cfg_data;
        CFG_ACTIVE_CHANNELS:   act_r <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_ADDQ;
      S_ADDQ: state_nxt = S_CHK;
      S_CHK: begin
        if (!in_range || den == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_XUPD;
      S_XUPD: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_PUPD;
      S_PUPD: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign div_req.start = (state_r == S_CHK) && in_range && (den != '0);
  assign div_req.num   = p1_r;
  assign div_req.den   = den;

  kfb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The one multiplier serves both products: the gain times the innovation
  // for the estimate, then one minus the gain times the predicted variance.
  always_comb begin
    if (state_r == S_MUL2) begin
      mul_a = {2'b00, p1_r};
      mul_b = {1'b0, ONE_FIX - k_r};
    end else begin
      mul_a = {{2{z_r[VAL_W-1]}}, z_r} - {{2{x_r[VAL_W-1]}}, x_r};
      mul_b = {1'b0, k_r};
    end
    mul_p = mul_a * mul_b;
  end

  // Taking the bits above the fraction of a signed product is a floor.
  assign delta = prod_r[FRAC_BITS+MUL_A_W-1:FRAC_BITS];
  assign xs    = {{3{x_r[VAL_W-1]}}, x_r} + {delta[MUL_A_W-1], delta};
  assign dx    = {{3{xn_r[VAL_W-1]}}, xn_r} - {{3{x_r[VAL_W-1]}}, x_r};

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ch_r <= in_channel;
          z_r  <= in_measurement;
        end
      end
      S_ADDQ: begin
        p1_r <= p_sum[VAL_W] ? '1 : p_sum[VAL_W-1:0];
        x_r  <= x_cur;
      end
      S_CHK: begin
        err_r <= !in_range || (den == '0);
      end
      S_DIV: begin
        if (div_rsp.done) begin
          k_r <= div_rsp.quot;
        end
      end
      S_MUL1: prod_r <= mul_p;
      S_XUPD: begin
        if (xs > XS_W'(32'sh7FFF_FFFF)) begin
          xn_r <= 32'sh7FFF_FFFF;
        end else if (xs < -(XS_W'(33'sh0_8000_0000))) begin
          xn_r <= 32'sh8000_0000;
        end else begin
          xn_r <= xs[VAL_W-1:0];
        end
      end
      S_MUL2: prod_r <= mul_p;
      S_PUPD: pn_r <= prod_r[FRAC_BITS+VAL_W-1:FRAC_BITS];
      default: ;
    endcase
  end

  // Store access: one registered read per cycle at the current channel, and
  // the write-back of the new estimate and variance.
  always_ff @(posedge clk) begin
    est_rd_r <= est_mem[idx];
    var_rd_r <= var_mem[idx];
    if (state_r == S_PUPD) begin
      est_mem[idx] <= xn_r;
      var_mem[idx] <= prod_r[FRAC_BITS+VAL_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      sum_r    <= '0;
    end else begin
      rd_vld_r <= vld_r[idx];
      if (state_r == S_PUPD) begin
        vld_r[idx] <= 1'b1;
        sum_r      <= sum_r + {{(SUM_W-XS_W){dx[XS_W-1]}}, dx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // A rejected beat reports zeros and the unchanged running sum.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= ch_r;
      out_sum_r  <= sum_r;
      out_err_r  <= err_r;
      out_est_r  <= err_r ? '0 : xn_r;
      out_gain_r <= err_r ? '0 : k_r;
      out_var_r  <= err_r ? '0 : pn_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel_out  = out_ch_r;
  assign out_estimate     = out_est_r;
  assign out_gain         = out_gain_r;
  assign out_variance     = out_var_r;
  assign out_estimate_sum = out_sum_r;
  assign out_error        = out_err_r;

  // A rejected beat carries no estimate, gain or variance.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_estimate == '0 && out_gain == '0 && out_variance == '0)
    else $error("rejected result carries nonzero fields");

  // The gain never exceeds 1.0.
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_gain <= ONE_FIX)
    else $error("gain above 1.0");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the division step");

  // The divider is started only on an in-range item, in the cycle after the
  // predicted variance was formed.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> in_range && $past(state_r) == S_ADDQ)
    else $error("divider started out of sequence");

  // No new beat is taken while an item is being worked on.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("input accepted while busy");

endmodule

`default_nettype wire
